FILE: hdl/button_gesture_and_rotary_events_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button gesture and rotary event block
// Shared shorthand for concurrent assertions clocked on a rising edge.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_AND_ROTARY_EVENTS_ASSERT_SVH
`define BUTTON_GESTURE_AND_ROTARY_EVENTS_ASSERT_SVH

// Assertion that is switched off while reset is high.
`define BGE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset.
`define BGE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/bge_pkg.sv
// ----------------------------------------------------------------------------
// bge_pkg
// Types, codes and default values shared by the button and rotary event block.
// ----------------------------------------------------------------------------
package bge_pkg;

   // Default widths of the time base and of the pending step count.
   localparam int TIME_BITS_DEF       = 32;
   localparam int STEP_COUNT_BITS_DEF = 8;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int IDLE_BITS      = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOUBLE_CLICK = 2'd2;

   // Register values after reset.
   localparam logic [CSR_DATA_BITS-1:0] DEBOUNCE_RST     = 16'd50;
   localparam logic [CSR_DATA_BITS-1:0] LONG_PRESS_RST   = 16'd1000;
   localparam logic [CSR_DATA_BITS-1:0] DOUBLE_CLICK_RST = 16'd300;

   // Button event codes.
   typedef enum logic [1:0] {
      BEV_NONE   = 2'd0,
      BEV_SHORT  = 2'd1,
      BEV_LONG   = 2'd2,
      BEV_DOUBLE = 2'd3
   } bev_type;

   // Rotary event codes.
   typedef enum logic [1:0] {
      REV_NONE = 2'd0,
      REV_CW   = 2'd1,
      REV_CCW  = 2'd2
   } rev_type;

   // Rotary step input codes.
   localparam logic [1:0] ROT_NONE = 2'b00;
   localparam logic [1:0] ROT_CW   = 2'b01;

   // One input word: a millisecond tick.
   typedef struct packed {
      logic              press_edge;
      logic              release_edge;
      logic              button_held;
      logic signed [1:0] rotary_step;
   } item_type;

   // Configuration register set.
   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] debounce_ms;
      logic [CSR_DATA_BITS-1:0] long_press_ms;
      logic [CSR_DATA_BITS-1:0] double_click_ms;
   } cfg_type;

   // One result word.
   typedef struct packed {
      bev_type              button_event;
      rev_type              rotary_event;
      logic                 activity_pending;
      logic [IDLE_BITS-1:0] idle_ms;
   } result_type;

endpackage

FILE: hdl/bge_csr.sv
// ----------------------------------------------------------------------------
// bge_csr
// Configuration registers: debounce, long press and double click times.
// ----------------------------------------------------------------------------
module bge_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bge_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bge_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output bge_pkg::cfg_type                  cfg
);
   import bge_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Decode the register index; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE:     cfg_in.debounce_ms     = csr_wdata;
            CSR_LONG_PRESS:   cfg_in.long_press_ms   = csr_wdata;
            CSR_DOUBLE_CLICK: cfg_in.double_click_ms = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms     <= DEBOUNCE_RST;
         cfg_ff.long_press_ms   <= LONG_PRESS_RST;
         cfg_ff.double_click_ms <= DOUBLE_CLICK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/bge_in_reg.sv
// ----------------------------------------------------------------------------
// bge_in_reg
// Input register that holds one tick word until the event stage takes it.
// ----------------------------------------------------------------------------
module bge_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bge_pkg::item_type req_item,
   input  logic              take,
   output logic              in_valid,
   output bge_pkg::item_type in_item
);
   import bge_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     load;

   // The register is free when empty or when its word moves on this cycle.
   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign in_valid = valid_ff;
   assign in_item  = item_ff;

endmodule

FILE: hdl/bge_core.sv
// ----------------------------------------------------------------------------
// bge_core
// Event logic for one tick: rotary debounce and pending count, button gesture
// classification, and the result register.
// ----------------------------------------------------------------------------
module bge_core #(
   parameter int TIME_BITS       = bge_pkg::TIME_BITS_DEF,
   parameter int STEP_COUNT_BITS = bge_pkg::STEP_COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  bge_pkg::item_type   in_item,
   input  bge_pkg::cfg_type    cfg,
   output logic                take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bge_pkg::result_type rsp_result
);
   import bge_pkg::*;

   localparam logic signed [STEP_COUNT_BITS-1:0] STEP_MAX =
      {1'b0, {(STEP_COUNT_BITS-1){1'b1}}};
   localparam logic signed [STEP_COUNT_BITS-1:0] STEP_MIN =
      {1'b1, {(STEP_COUNT_BITS-1){1'b0}}};

   typedef logic [TIME_BITS-1:0] time_type;

   // State registers and their next values.
   time_type                          now_ff, now_in;
   time_type                          press_start_ff, press_start_in;
   time_type                          last_release_ff, last_release_in;
   time_type                          last_step_ff, last_step_in;
   time_type                          last_activity_ff, last_activity_in;
   logic                              long_reported_ff, long_reported_in;
   logic                              awaiting_ff, awaiting_in;
   logic signed [STEP_COUNT_BITS-1:0] pending_ff, pending_in;
   logic                              out_valid_ff;
   result_type                        result_ff, result_in;

   // Intermediate values.
   logic                              step_ok;
   logic signed [STEP_COUNT_BITS-1:0] pending_mid;
   time_type                          hold_time;
   time_type                          since_release;
   time_type                          idle_t;
   logic                              long_hit;
   bev_type                           bev;
   rev_type                           rev;

   // A word moves on when the result register is empty or being emptied.
   assign take = in_valid && (!out_valid_ff || !rsp_stall);

   // Rotary step: debounce against the last accepted step, then saturate.
   always_comb begin
      step_ok      = (in_item.rotary_step != ROT_NONE) &&
                     ((now_ff - last_step_ff) >= TIME_BITS'(cfg.debounce_ms));
      pending_mid  = pending_ff;
      last_step_in = last_step_ff;
      if (step_ok) begin
         last_step_in = now_ff;
         if (in_item.rotary_step == ROT_CW) begin
            if (pending_ff < STEP_MAX) begin
               pending_mid = pending_ff + STEP_COUNT_BITS'(1);
            end
         end else begin
            if (pending_ff > STEP_MIN) begin
               pending_mid = pending_ff - STEP_COUNT_BITS'(1);
            end
         end
      end
   end

   // Button gestures: press, then release, then long hold, then window timeout.
   always_comb begin
      press_start_in   = in_item.press_edge ? now_ff : press_start_ff;
      long_reported_in = in_item.press_edge ? 1'b0 : long_reported_ff;
      last_release_in  = last_release_ff;
      awaiting_in      = awaiting_ff;
      hold_time        = now_ff - press_start_in;
      since_release    = now_ff - last_release_ff;
      long_hit         = in_item.button_held && !long_reported_in &&
                         (hold_time >= TIME_BITS'(cfg.long_press_ms));
      bev              = BEV_NONE;
      if (in_item.release_edge) begin
         last_release_in = now_ff;
         if (long_reported_in) begin
            bev = BEV_NONE;
         end else if (hold_time >= TIME_BITS'(cfg.long_press_ms)) begin
            bev = BEV_LONG;
         end else if (awaiting_ff) begin
            awaiting_in = 1'b0;
            bev         = BEV_DOUBLE;
         end else begin
            awaiting_in = 1'b1;
         end
      end else if (long_hit) begin
         long_reported_in = 1'b1;
         bev              = BEV_LONG;
      end else if (awaiting_ff && (since_release > TIME_BITS'(cfg.double_click_ms))) begin
         awaiting_in = 1'b0;
         bev         = BEV_SHORT;
      end
   end

   // Pop one pending step and form the result word.
   always_comb begin
      pending_in = pending_mid;
      rev        = REV_NONE;
      if (pending_mid > STEP_COUNT_BITS'(0)) begin
         pending_in = pending_mid - STEP_COUNT_BITS'(1);
         rev        = REV_CW;
      end else if (pending_mid < STEP_COUNT_BITS'(0)) begin
         pending_in = pending_mid + STEP_COUNT_BITS'(1);
         rev        = REV_CCW;
      end

      if (step_ok || in_item.press_edge || in_item.release_edge) begin
         last_activity_in = now_ff;
      end else begin
         last_activity_in = last_activity_ff;
      end
      idle_t = now_ff - last_activity_in;
      now_in = now_ff + TIME_BITS'(1);

      result_in.button_event     = bev;
      result_in.rotary_event     = rev;
      result_in.activity_pending = (pending_in != STEP_COUNT_BITS'(0)) ||
                                   in_item.button_held || awaiting_in;
      result_in.idle_ms          = IDLE_BITS'(idle_t);
   end

   // State advances once per taken word.
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff           <= '0;
         press_start_ff   <= '0;
         last_release_ff  <= '0;
         last_step_ff     <= '0;
         last_activity_ff <= '0;
         long_reported_ff <= 1'b0;
         awaiting_ff      <= 1'b0;
         pending_ff       <= '0;
      end else if (take) begin
         now_ff           <= now_in;
         press_start_ff   <= press_start_in;
         last_release_ff  <= last_release_in;
         last_step_ff     <= last_step_in;
         last_activity_ff <= last_activity_in;
         long_reported_ff <= long_reported_in;
         awaiting_ff      <= awaiting_in;
         pending_ff       <= pending_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (take) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = result_ff;

endmodule

FILE: hdl/button_gesture_and_rotary_events.sv
// ----------------------------------------------------------------------------
// button_gesture_and_rotary_events
// Per-millisecond button gesture and rotary step event block.
//
//   channel   direction  handshake          payload
//   req_      in         valid / stall      press, release, held, rotary step
//   rsp_      out        valid / stall      button, rotary, pending, idle ms
//   csr_      in         valid / ready      register index, 16-bit data
//
// One tick word is taken per cycle while req_stall is low; it passes the input
// register and then the result register, from which rsp_ offers its result.
// All event logic is a single pass between those two registers.
// Reset is synchronous and clears all timers, flags and the step count.
// A stall on rsp_ holds the result; req_stall rises only while both registers
// are full and the result is stalled.
// ----------------------------------------------------------------------------
module button_gesture_and_rotary_events #(
   parameter int TIME_BITS       = bge_pkg::TIME_BITS_DEF,
   parameter int STEP_COUNT_BITS = bge_pkg::STEP_COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_press_edge,
   input  logic                               req_release_edge,
   input  logic                               req_button_held,
   input  logic signed [1:0]                  req_rotary_step,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_button_event,
   output logic [1:0]                         rsp_rotary_event,
   output logic                               rsp_activity_pending,
   output logic [bge_pkg::IDLE_BITS-1:0]      rsp_idle_ms,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bge_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bge_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import bge_pkg::*;

   item_type   req_item;
   item_type   in_item;
   cfg_type    cfg;
   result_type rsp_result;
   logic       in_valid;
   logic       take;

   // Gather the input word.
   assign req_item.press_edge   = req_press_edge;
   assign req_item.release_edge = req_release_edge;
   assign req_item.button_held  = req_button_held;
   assign req_item.rotary_step  = req_rotary_step;

   bge_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bge_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .take      (take),
      .in_valid  (in_valid),
      .in_item   (in_item)
   );

   bge_core #(
      .TIME_BITS       (TIME_BITS),
      .STEP_COUNT_BITS (STEP_COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid),
      .in_item    (in_item),
      .cfg        (cfg),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   // Split the result word onto its ports.
   assign rsp_button_event     = rsp_result.button_event;
   assign rsp_rotary_event     = rsp_result.rotary_event;
   assign rsp_activity_pending = rsp_result.activity_pending;
   assign rsp_idle_ms          = rsp_result.idle_ms;

endmodule

FILE: hdl/bge_checker.sv
// ----------------------------------------------------------------------------
// bge_checker
// Port-level checks for the button gesture and rotary event block.
// ----------------------------------------------------------------------------
`include "button_gesture_and_rotary_events_assert.svh"

module bge_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [1:0]                         rsp_rotary_event,
   input logic [bge_pkg::IDLE_BITS-1:0]      rsp_idle_ms
);
   import bge_pkg::*;

   // No result is offered in the cycle after reset.
   `BGE_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid, "result after reset")

   // The input side only backs up behind a stalled result.
   `BGE_ASSERT(a_stall_cause, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "input stalled without a stalled result")

   // The rotary event never carries the unused code.
   `BGE_ASSERT(a_rotary_code, clock, reset, rsp_valid |-> (rsp_rotary_event != 2'd3), "bad rotary event code")

   // A stalled result stays valid and keeps its idle count.
   `BGE_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_idle_ms)), "stalled result changed")

endmodule

bind button_gesture_and_rotary_events bge_checker u_bge_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_rotary_event (rsp_rotary_event),
   .rsp_idle_ms      (rsp_idle_ms)
);

FILE: bench/bge_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bge_event_checker
// Watches the tick, result and register channels of the button and rotary
// event block. It keeps its own copy of the timers, flags and settings. It
// works out the result word that each accepted tick word must produce, and it
// compares every accepted result word with the oldest one still waiting.
// ----------------------------------------------------------------------------
module bge_event_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_press_edge,
   input  logic                               req_release_edge,
   input  logic                               req_button_held,
   input  logic signed [1:0]                  req_rotary_step,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [1:0]                         rsp_button_event,
   input  logic [1:0]                         rsp_rotary_event,
   input  logic                               rsp_activity_pending,
   input  logic [bge_pkg::IDLE_BITS-1:0]      rsp_idle_ms,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [bge_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bge_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int unsigned                        error_count,
   output int unsigned                        queued
);
   import bge_pkg::*;

   localparam int TB = TIME_BITS_DEF;
   localparam int SB = STEP_COUNT_BITS_DEF;
   localparam logic signed [SB-1:0] STEP_HI = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] STEP_LO = {1'b1, {(SB-1){1'b0}}};

   // Settings as last written.
   logic [CSR_DATA_BITS-1:0] debounce_ms;
   logic [CSR_DATA_BITS-1:0] long_press_ms;
   logic [CSR_DATA_BITS-1:0] double_click_ms;

   // Timers and flags of the gesture logic.
   logic [TB-1:0]        clock_ms;
   logic [TB-1:0]        press_start_ms;
   logic [TB-1:0]        last_release_ms;
   logic [TB-1:0]        last_step_ms;
   logic [TB-1:0]        last_activity_ms;
   logic                 long_reported;
   logic                 awaiting_second;
   logic signed [SB-1:0] step_count;

   // Result words still to come, oldest first.
   result_type tick_results_q[$];

   // Advances the gesture state by one millisecond tick and returns its result.
   function automatic result_type tick_outcome(input item_type w);
      logic [TB-1:0] t;
      logic [TB-1:0] since_press;
      bev_type       bev;
      rev_type       rev;
      logic          decided;
      result_type    r;
      t       = clock_ms;
      bev     = BEV_NONE;
      rev     = REV_NONE;
      decided = 1'b0;

      // A rotary step counts only once the spacing since the last one has passed.
      if (w.rotary_step != ROT_NONE && (t - last_step_ms) >= debounce_ms) begin
         if (w.rotary_step == ROT_CW) begin
            if (step_count != STEP_HI) step_count = step_count + SB'(1);
         end else begin
            if (step_count != STEP_LO) step_count = step_count - SB'(1);
         end
         last_step_ms     = t;
         last_activity_ms = t;
      end

      // The press edge is taken before the release edge of the same tick.
      if (w.press_edge) begin
         press_start_ms   = t;
         long_reported    = 1'b0;
         last_activity_ms = t;
      end
      since_press = t - press_start_ms;

      // A release ends the button evaluation whatever it reports.
      if (w.release_edge) begin
         last_release_ms  = t;
         last_activity_ms = t;
         decided          = 1'b1;
         if (long_reported) begin
            bev = BEV_NONE;
         end else if (since_press >= long_press_ms) begin
            bev = BEV_LONG;
         end else if (awaiting_second) begin
            awaiting_second = 1'b0;
            bev             = BEV_DOUBLE;
         end else begin
            awaiting_second = 1'b1;
         end
      end

      // Long press while still held, reported once per press.
      if (!decided && w.button_held && !long_reported && since_press >= long_press_ms) begin
         long_reported = 1'b1;
         bev           = BEV_LONG;
         decided       = 1'b1;
      end

      // A lone click becomes a short press once the window has strictly passed.
      if (!decided && awaiting_second && (t - last_release_ms) > double_click_ms) begin
         awaiting_second = 1'b0;
         bev             = BEV_SHORT;
      end

      // One pending step leaves per tick.
      if (step_count > 0) begin
         step_count = step_count - SB'(1);
         rev        = REV_CW;
      end else if (step_count < 0) begin
         step_count = step_count + SB'(1);
         rev        = REV_CCW;
      end

      r.button_event     = bev;
      r.rotary_event     = rev;
      r.activity_pending = (step_count != 0) || w.button_held || awaiting_second;
      r.idle_ms          = IDLE_BITS'(t - last_activity_ms);
      clock_ms           = t + 1'b1;
      return r;
   endfunction

   // Channel monitor: register writes, tick words and result words.
   always @(posedge clock) begin
      item_type   w;
      result_type exp_r;
      if (reset) begin
         debounce_ms      = DEBOUNCE_RST;
         long_press_ms    = LONG_PRESS_RST;
         double_click_ms  = DOUBLE_CLICK_RST;
         clock_ms         = '0;
         press_start_ms   = '0;
         last_release_ms  = '0;
         last_step_ms     = '0;
         last_activity_ms = '0;
         long_reported    = 1'b0;
         awaiting_second  = 1'b0;
         step_count       = '0;
         tick_results_q.delete();
         queued           = 0;
         error_count      = 0;
      end else begin
         // Register writes only happen while the block is drained.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEBOUNCE:     debounce_ms     = csr_wdata;
               CSR_LONG_PRESS:   long_press_ms   = csr_wdata;
               CSR_DOUBLE_CLICK: double_click_ms = csr_wdata;
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            w.press_edge   = req_press_edge;
            w.release_edge = req_release_edge;
            w.button_held  = req_button_held;
            w.rotary_step  = req_rotary_step;
            tick_results_q.push_back(tick_outcome(w));
         end

         // Compare each result word with the oldest expectation.
         if (rsp_valid && !rsp_stall) begin
            if (tick_results_q.size() == 0) begin
               $error("result word arrived with no expected word waiting");
               error_count = error_count + 1;
            end else begin
               exp_r = tick_results_q.pop_front();
               if (rsp_button_event !== exp_r.button_event) begin
                  $error("button_event: expected %0d, actual %0d",
                         exp_r.button_event, rsp_button_event);
                  error_count = error_count + 1;
               end
               if (rsp_rotary_event !== exp_r.rotary_event) begin
                  $error("rotary_event: expected %0d, actual %0d",
                         exp_r.rotary_event, rsp_rotary_event);
                  error_count = error_count + 1;
               end
               if (rsp_activity_pending !== exp_r.activity_pending) begin
                  $error("activity_pending: expected %0d, actual %0d",
                         exp_r.activity_pending, rsp_activity_pending);
                  error_count = error_count + 1;
               end
               if (rsp_idle_ms !== exp_r.idle_ms) begin
                  $error("idle_ms: expected %0d, actual %0d", exp_r.idle_ms, rsp_idle_ms);
                  error_count = error_count + 1;
               end
            end
         end
         queued = tick_results_q.size();
      end
   end

endmodule

FILE: bench/tb_button_gesture_and_rotary_events.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_gesture_and_rotary_events
// Drives millisecond tick words into the button and rotary event block. It
// starts with a directed set of gestures and then runs randomized click, hold
// and rotary sequences under several register settings and idling profiles,
// including one long hold-off on the result side. The checker beside the
// block does all predicting and comparing; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_button_gesture_and_rotary_events;
   import bge_pkg::*;

   // Counterclockwise step codes: the normal one and the two-step pattern.
   localparam logic [1:0] ROT_CCW     = 2'b11;
   localparam logic [1:0] ROT_CCW_ALT = 2'b10;

   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 72;
   localparam int HOLD_OFF_AT  = 450;
   localparam int HOLD_OFF_LEN = 60;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 8;

   logic                      clock;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic                      req_press_edge   = 1'b0;
   logic                      req_release_edge = 1'b0;
   logic                      req_button_held  = 1'b0;
   logic signed [1:0]         req_rotary_step  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic [1:0]                rsp_button_event;
   logic [1:0]                rsp_rotary_event;
   logic                      rsp_activity_pending;
   logic [IDLE_BITS-1:0]      rsp_idle_ms;
   logic                      csr_valid        = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata        = '0;
   int unsigned               error_count;
   int unsigned               queued;

   int unsigned accepted_words = 0;
   int unsigned quiet_cycles   = 0;
   int          hold_left      = 0;
   bit          hold_done      = 1'b0;

   button_gesture_and_rotary_events DUT (.*);

   bge_event_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Count accepted tick words; the idling profile follows this count.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) accepted_words <= accepted_words + 1;
   end

   // Watchdog: too long without any handshake ends the run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** button_gesture_and_rotary_events: FAILED **");
         $finish;
      end
   end

   // Idling profile: sender light and receiver heavy, then reversed, then none.
   function automatic int sender_gap_pct();
      if (accepted_words < 200) return 10;
      if (accepted_words < 400) return 79;
      return 0;
   endfunction

   function automatic int receiver_stall_pct();
      if (accepted_words < 200) return 79;
      if (accepted_words < 400) return 10;
      return 0;
   endfunction

   // Result side: random stalls plus one long hold-off while words keep coming.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
         end else if (!hold_done && accepted_words >= HOLD_OFF_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_LEN - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct());
         end
      end
   end

   // Offers one tick word, after an optional gap, and waits for it to be taken.
   task automatic send_tick(input logic press, input logic rel, input logic held,
                            input logic [1:0] rot);
      while ($urandom_range(99) < sender_gap_pct()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_press_edge   <= press;
      req_release_edge <= rel;
      req_button_held  <= held;
      req_rotary_step  <= rot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stops offering words and waits until every result word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (queued != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_settings(input logic [15:0] deb, input logic [15:0] lp,
                                 input logic [15:0] dc);
      csr_write(CSR_DEBOUNCE, deb);
      csr_write(CSR_LONG_PRESS, lp);
      csr_write(CSR_DOUBLE_CLICK, dc);
      csr_valid <= 1'b0;
   endtask

   // Mostly no step, otherwise any of the step codes.
   function automatic logic [1:0] rand_rot();
      case ($urandom_range(9))
         6, 7:    return ROT_CW;
         8:       return ROT_CCW;
         9:       return ROT_CCW_ALT;
         default: return ROT_NONE;
      endcase
   endfunction

   // One well-formed gesture: press, hold, release, then a quiet gap.
   task automatic send_gesture(inout int sent);
      int hold_ticks;
      int gap_ticks;
      hold_ticks = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
      gap_ticks  = ($urandom_range(4) == 0) ? $urandom_range(30) : $urandom_range(4);
      if ($urandom_range(9) == 0) begin
         send_tick(1'b1, 1'b1, 1'b0, rand_rot());
         sent = sent + 1;
      end else begin
         send_tick(1'b1, 1'b0, 1'b1, rand_rot());
         repeat (hold_ticks) send_tick(1'b0, 1'b0, 1'b1, rand_rot());
         send_tick(1'b0, 1'b1, 1'b0, rand_rot());
         sent = sent + hold_ticks + 2;
      end
      repeat (gap_ticks) send_tick(1'b0, 1'b0, 1'b0, rand_rot());
      sent = sent + gap_ticks;
   endtask

   initial begin
      int sent;
      logic [15:0] deb, lp, dc;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: steps right after time zero are rejected, including
      // the two-step pattern; press and release together; held with no edge.
      send_tick(1'b0, 1'b0, 1'b0, ROT_CW);
      send_tick(1'b0, 1'b0, 1'b0, ROT_CCW_ALT);
      send_tick(1'b1, 1'b1, 1'b0, ROT_NONE);
      send_tick(1'b0, 1'b0, 1'b1, ROT_NONE);
      drain();
      write_settings(16'd0, 16'd3, 16'd2);

      // Every step code is accepted with no spacing.
      send_tick(1'b0, 1'b0, 1'b0, ROT_CCW_ALT);
      send_tick(1'b0, 1'b0, 1'b0, ROT_CW);
      send_tick(1'b0, 1'b0, 1'b0, ROT_CCW);
      // Long press while held, then a release that reports nothing.
      send_tick(1'b1, 1'b0, 1'b1, ROT_NONE);
      repeat (3) send_tick(1'b0, 1'b0, 1'b1, ROT_NONE);
      send_tick(1'b0, 1'b1, 1'b0, ROT_NONE);
      // Double click.
      send_tick(1'b1, 1'b0, 1'b1, ROT_NONE);
      send_tick(1'b0, 1'b1, 1'b0, ROT_NONE);
      send_tick(1'b1, 1'b0, 1'b1, ROT_NONE);
      send_tick(1'b0, 1'b1, 1'b0, ROT_NONE);
      // Short press once the window runs out, just past its edge.
      send_tick(1'b1, 1'b1, 1'b0, ROT_NONE);
      repeat (3) send_tick(1'b0, 1'b0, 1'b0, ROT_NONE);
      // Long press reported on release after an unheld wait.
      send_tick(1'b1, 1'b0, 1'b1, ROT_NONE);
      repeat (2) send_tick(1'b0, 1'b0, 1'b0, ROT_NONE);
      send_tick(1'b0, 1'b1, 1'b0, ROT_NONE);
      // Every input bit high at once.
      send_tick(1'b1, 1'b1, 1'b1, ROT_CCW);
      drain();

      // Random phases under a range of settings, the extremes among them.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin deb = 16'd3;     lp = 16'd12;    dc = 16'd6;     end
            1: begin deb = 16'd0;     lp = 16'd0;     dc = 16'd0;     end
            2: begin deb = 16'hFFFF;  lp = 16'hFFFF;  dc = 16'hFFFF;  end
            3: begin deb = 16'd1;     lp = 16'd8;     dc = 16'd4;     end
            4: begin deb = 16'd10;    lp = 16'd40;    dc = 16'd20;    end
            default: begin
               deb = 16'($urandom_range(8));
               lp  = 16'($urandom_range(30));
               dc  = 16'($urandom_range(15));
            end
         endcase
         write_settings(deb, lp, dc);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            // Mostly gestures; the rest is noise with every field random.
            if ($urandom_range(4) == 0) begin
               send_tick(1'($urandom), 1'($urandom), 1'($urandom), 2'($urandom));
               sent = sent + 1;
            end else begin
               send_gesture(sent);
            end
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("** button_gesture_and_rotary_events: PASSED **");
      else
         $display("** button_gesture_and_rotary_events: FAILED **");
      $finish;
   end

endmodule
